[hdl/plt_pkg.sv]
// ============================================================================
// plt_pkg
// shared types and constants for the peer liveness table
// ============================================================================
package plt_pkg;

    localparam int PEER_SLOTS = 16;
    localparam int IDX_W      = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;
    localparam int SLOT_W     = 4;
    localparam int DIV_W      = 32;
    localparam int CNT_W      = $clog2(DIV_W);
    localparam logic [7:0] MISS_SAT = 8'd255;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_FRAME = 2'd1,
        OP_BYE   = 2'd2,
        OP_TICK  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        PS_FREE  = 3'd0,
        PS_KNOWN = 3'd1,
        PS_ALIVE = 3'd2,
        PS_DEAD  = 3'd3,
        PS_LEFT  = 3'd4
    } t_pstate;

    typedef enum logic [2:0] {
        CH_NONE    = 3'd0,
        CH_ALIVE   = 3'd1,
        CH_DEAD    = 3'd2,
        CH_REVIVED = 3'd3,
        CH_REBOOT  = 3'd4,
        CH_LEFT    = 3'd5,
        CH_STALE   = 3'd6
    } t_change;

    typedef enum logic [1:0] {
        RS_OK       = 2'd0,
        RS_NOTFOUND = 2'd1,
        RS_FULL     = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic clr_idx;
        logic inc_idx;
        logic div_start;
        logic div_step;
        logic apply;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        t_op  op;
        logic hit;
        logic idx_last;
        logic need_div;
        logic div_last;
    } t_stat;

endpackage

[hdl/plt_if.sv]
// ============================================================================
// plt_in_if / plt_out_if
// valid/ready channels carrying request and result items
// ============================================================================
interface plt_in_if;
    import plt_pkg::*;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [47:0] peer_mac;
    logic [15:0] peer_node;
    logic [31:0] now_time;
    logic [31:0] epoch_in;
    logic [31:0] period_in;
    logic [7:0]  limit_in;
    modport source (output valid, op, peer_mac, peer_node, now_time, epoch_in,
                    period_in, limit_in, input ready);
    modport sink   (input valid, op, peer_mac, peer_node, now_time, epoch_in,
                    period_in, limit_in, output ready);
endinterface

interface plt_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] change;
    logic [1:0] status;
    logic [3:0] slot;
    logic [2:0] peer_state_out;
    logic [7:0] miss_count;
    logic       last_result;
    modport source (output valid, change, status, slot, peer_state_out, miss_count,
                    last_result, input ready);
    modport sink   (input valid, change, status, slot, peer_state_out, miss_count,
                    last_result, output ready);
endinterface

[hdl/peer_liveness_table.sv]
// ============================================================================
// peer_liveness_table
// heartbeat failure detector over a table of peer slots
// ============================================================================
//  channel  | dir | modport | carries
//  i_in     | in  | sink    | op, peer_mac, peer_node, now_time, epoch_in,
//           |     |         | period_in, limit_in
//  o_out    | out | source  | change, status, slot, peer_state_out,
//           |     |         | miss_count, last_result
//
//  add/frame/bye: scan one slot a cycle from slot 0 up to the first matching
//  slot, or up to the last slot (PEER_SLOTS - 1) if none matches
//  tick: per slot, a bit-serial divide on a live slot with a nonzero
//  period; one result per slot
//  reset: synchronous, clears slot states, miss counts and epochs at once
//  a stalled result holds the sequencer; no new transfer until it is taken
// ============================================================================
module peer_liveness_table
    import plt_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    plt_in_if.sink    i_in,
    plt_out_if.source o_out
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    plt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // table, divider and result register
    plt_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_stat           (w_stat),
        .i_op             (i_in.op),
        .i_peer_mac       (i_in.peer_mac),
        .i_peer_node      (i_in.peer_node),
        .i_now_time       (i_in.now_time),
        .i_epoch_in       (i_in.epoch_in),
        .i_period_in      (i_in.period_in),
        .i_limit_in       (i_in.limit_in),
        .o_change         (o_out.change),
        .o_status         (o_out.status),
        .o_slot           (o_out.slot),
        .o_peer_state_out (o_out.peer_state_out),
        .o_miss_count     (o_out.miss_count),
        .o_last_result    (o_out.last_result)
    );

endmodule

[hdl/plt_ctrl.sv]
// ============================================================================
// plt_ctrl
// sequencer: slot scan, per-slot divide and result handoff
// ============================================================================
module plt_ctrl
    import plt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_DIV   = 5'b00100,
        S_APPLY = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_idx = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.op == OP_TICK) begin
                    if (i_stat.need_div) begin
                        o_cmd.div_start = 1'b1;
                        n_state         = S_DIV;
                    end else begin
                        n_state = S_APPLY;
                    end
                end else if (i_stat.hit || i_stat.idx_last) begin
                    n_state = S_APPLY;
                end else begin
                    o_cmd.inc_idx = 1'b1;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.op == OP_TICK && !i_stat.idx_last) begin
                        o_cmd.inc_idx = 1'b1;
                        n_state       = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[hdl/plt_dp.sv]
// ============================================================================
// plt_dp
// slot table, request latch, serial divider and result register
// ============================================================================
module plt_dp
    import plt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_op,
    input  logic [47:0] i_peer_mac,
    input  logic [15:0] i_peer_node,
    input  logic [31:0] i_now_time,
    input  logic [31:0] i_epoch_in,
    input  logic [31:0] i_period_in,
    input  logic [7:0]  i_limit_in,
    output logic [2:0]  o_change,
    output logic [1:0]  o_status,
    output logic [3:0]  o_slot,
    output logic [2:0]  o_peer_state_out,
    output logic [7:0]  o_miss_count,
    output logic        o_last_result
);

    // latched request
    t_op         r_op;
    logic [47:0] r_mac;
    logic [15:0] r_node;
    logic [31:0] r_now;
    logic [31:0] r_epoch;
    logic [31:0] r_period;
    logic [7:0]  r_limit;
    logic [IDX_W-1:0] r_idx;

    // slot table
    t_pstate     r_state  [PEER_SLOTS];
    logic [7:0]  r_misses [PEER_SLOTS];
    logic [31:0] r_sepoch [PEER_SLOTS];
    logic [47:0] r_smac   [PEER_SLOTS];
    logic [15:0] r_snode  [PEER_SLOTS];
    logic [31:0] r_lastrx [PEER_SLOTS];
    logic [31:0] r_speriod[PEER_SLOTS];
    logic [7:0]  r_slimit [PEER_SLOTS];

    // divider
    logic [DIV_W:0]   r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W:0]   w_rem_sh;
    logic [DIV_W:0]   w_rem_sub;

    // current slot view
    t_pstate     w_st;
    logic [7:0]  w_miss;
    logic [31:0] w_ep;
    logic        w_live;
    logic        w_hit;
    logic        w_last;
    logic [7:0]  w_sat;
    logic        w_stale;
    logic        w_reboot;

    t_change     n_change;
    t_status     n_status;
    t_pstate     n_pstate;
    logic [7:0]  n_miss;
    logic        n_wr_lookup;
    logic        n_wr_add;
    logic        n_wr_tick;

    assign w_st   = r_state[r_idx];
    assign w_miss = r_misses[r_idx];
    assign w_ep   = r_sepoch[r_idx];
    assign w_live = (w_st == PS_KNOWN) || (w_st == PS_ALIVE);
    assign w_last = (r_idx == IDX_W'(PEER_SLOTS - 1));

    always_comb begin
        if (r_op == OP_ADD) begin
            w_hit = (w_st == PS_FREE);
        end else begin
            w_hit = (w_st != PS_FREE) && (r_smac[r_idx] == r_mac);
        end
    end

    assign w_sat    = (|r_quo[DIV_W-1:8]) ? MISS_SAT : r_quo[7:0];
    assign w_stale  = (r_epoch != '0) && (w_ep != '0) && (r_epoch < w_ep);
    assign w_reboot = (r_epoch != '0) && (w_ep != '0) && (r_epoch > w_ep);

    assign o_stat.op       = r_op;
    assign o_stat.hit      = w_hit;
    assign o_stat.idx_last = w_last;
    assign o_stat.need_div = w_live && (r_speriod[r_idx] != '0);
    assign o_stat.div_last = (r_cnt == CNT_W'(DIV_W - 1));

    // restoring divide, one quotient bit per cycle
    assign w_rem_sh  = {r_rem[DIV_W-1:0], r_quo[DIV_W-1]};
    assign w_rem_sub = w_rem_sh - {1'b0, r_speriod[r_idx]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem <= '0;
            r_quo <= r_now - r_lastrx[r_idx];
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            if (!w_rem_sub[DIV_W]) begin
                r_rem <= w_rem_sub;
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                r_rem <= w_rem_sh;
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end
            r_cnt <= r_cnt + CNT_W'(1);
        end
    end

    // outcome for the slot under the pointer
    always_comb begin
        n_change    = CH_NONE;
        n_status    = RS_OK;
        n_pstate    = w_st;
        n_miss      = w_miss;
        n_wr_lookup = 1'b0;
        n_wr_add    = 1'b0;
        n_wr_tick   = 1'b0;
        unique case (r_op)
            OP_ADD: begin
                if (w_hit) begin
                    n_pstate = PS_KNOWN;
                    n_miss   = '0;
                    n_wr_add = 1'b1;
                end else begin
                    n_status = RS_FULL;
                    n_pstate = PS_FREE;
                    n_miss   = '0;
                end
            end
            OP_FRAME: begin
                if (!w_hit) begin
                    n_status = RS_NOTFOUND;
                    n_pstate = PS_FREE;
                    n_miss   = '0;
                end else if (w_stale) begin
                    n_change = CH_STALE;
                end else begin
                    n_wr_lookup = 1'b1;
                    n_pstate    = PS_ALIVE;
                    n_miss      = '0;
                    if (w_reboot) begin
                        n_change = CH_REBOOT;
                    end else if (w_st == PS_DEAD) begin
                        n_change = CH_REVIVED;
                    end else if (w_st == PS_KNOWN || w_st == PS_LEFT) begin
                        n_change = CH_ALIVE;
                    end
                end
            end
            OP_BYE: begin
                if (!w_hit) begin
                    n_status = RS_NOTFOUND;
                    n_pstate = PS_FREE;
                    n_miss   = '0;
                end else begin
                    n_wr_lookup = 1'b1;
                    n_pstate    = PS_LEFT;
                    n_miss      = '0;
                    n_change    = (w_st == PS_LEFT) ? CH_NONE : CH_LEFT;
                end
            end
            OP_TICK: begin
                if (w_live) begin
                    n_wr_tick = 1'b1;
                    n_miss    = (r_speriod[r_idx] != '0) ? w_sat : 8'd0;
                    if (n_miss >= r_slimit[r_idx]) begin
                        n_pstate = PS_DEAD;
                        n_change = CH_DEAD;
                    end
                end
            end
            default: ;
        endcase
    end

    // request latch and pointer
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op     <= t_op'(i_op);
            r_mac    <= i_peer_mac;
            r_node   <= i_peer_node;
            r_now    <= i_now_time;
            r_epoch  <= i_epoch_in;
            r_period <= i_period_in;
            r_limit  <= i_limit_in;
        end
        if (i_cmd.clr_idx) begin
            r_idx <= '0;
        end else if (i_cmd.inc_idx) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // slot fields with a defined reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PEER_SLOTS; k++) begin
                r_state[k]  <= PS_FREE;
                r_misses[k] <= '0;
                r_sepoch[k] <= '0;
            end
        end else if (i_cmd.apply && (n_wr_add || n_wr_lookup || n_wr_tick)) begin
            r_state[r_idx]  <= n_pstate;
            r_misses[r_idx] <= n_miss;
            if (n_wr_add) begin
                r_sepoch[r_idx] <= '0;
            end else if (n_wr_lookup && r_op == OP_FRAME && r_epoch != '0) begin
                r_sepoch[r_idx] <= r_epoch;
            end
        end
    end

    // slot fields undefined until written
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            if (n_wr_add) begin
                r_smac[r_idx]    <= r_mac;
                r_snode[r_idx]   <= r_node;
                r_speriod[r_idx] <= r_period;
                r_slimit[r_idx]  <= r_limit;
            end
            if (n_wr_add || n_wr_lookup) begin
                r_lastrx[r_idx] <= r_now;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply) begin
            o_change         <= n_change;
            o_status         <= n_status;
            o_slot           <= (n_status == RS_OK) ? SLOT_W'(r_idx) : '0;
            o_peer_state_out <= n_pstate;
            o_miss_count     <= n_miss;
            o_last_result    <= (r_op != OP_TICK) || w_last;
        end
    end

    // node id is held for the table only
    logic w_node_unused;
    assign w_node_unused = ^r_snode[r_idx];

endmodule
